### design/sacc_pkg.sv
// ---------------------------------------------------------------------------
// sacc_pkg: shared types and constants
// Geometry limits, line record layout and register codes of the cache tag
// controller.
// ---------------------------------------------------------------------------
package sacc_pkg;

	localparam int MAX_LINES_LOG2 = 10;
	localparam int MAX_WAYS_LOG2  = 4;
	localparam int OFFSET_BITS    = 6;
	localparam int ADDRESS_BITS   = 48;

	localparam int LANES     = 1 << MAX_WAYS_LOG2;          // lines per memory row
	localparam int LANE_BITS = MAX_WAYS_LOG2;
	localparam int LINE_BITS = MAX_LINES_LOG2;
	localparam int ROW_BITS  = MAX_LINES_LOG2 - MAX_WAYS_LOG2;
	localparam int ROWS      = 1 << ROW_BITS;
	localparam int TAG_BITS  = ADDRESS_BITS - OFFSET_BITS;
	localparam int RANK_BITS = 4;
	localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

	// configuration register widths
	localparam int LINES_CFG_BITS = 4;
	localparam int WAYS_CFG_BITS  = 3;
	localparam int CFG_DATA_BITS  = 4;
	localparam int CFG_IDX_BITS   = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_REPLACEMENT = 2'd0,
		REG_WRITE_POL   = 2'd1,
		REG_LINES_LOG2  = 2'd2,
		REG_WAYS_LOG2   = 2'd3
	} reg_idx_t;

	localparam logic REQ_WRITE = 1'b1;
	localparam logic REPL_FIFO = 1'b1;
	localparam logic WPOL_BACK = 1'b1;

	typedef struct packed {
		logic                 repl;
		logic                 wpol;
		logic [LINES_CFG_BITS-1:0] lines_log2;
		logic [WAYS_CFG_BITS-1:0]  ways_log2;
	} cfg_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic                 valid;
		logic                 dirty;
		logic [RANK_BITS-1:0] use_rank;
		logic [RANK_BITS-1:0] fill_rank;
	} line_t;

	typedef line_t [LANES-1:0] row_t;

	typedef struct packed {
		logic                 hit;
		logic                 mem_read;
		logic                 mem_write;
		logic [LANE_BITS-1:0] way;
		logic                 config_error;
	} res_t;

endpackage

### design/sacc_ifs.sv
// ---------------------------------------------------------------------------
// sacc_ifs: request and response channels
// Valid/ready channels carrying one access request and one lookup result.
// ---------------------------------------------------------------------------
interface sacc_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [sacc_pkg::ADDRESS_BITS-1:0] address;

	modport source (output valid, output req_type, output address, input ready);
	modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface sacc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic                           mem_read;
	logic                           mem_write;
	logic [sacc_pkg::LANE_BITS-1:0] way_used;
	logic                           config_error;

	modport source (output valid, output hit, output mem_read, output mem_write,
		output way_used, output config_error, input ready);
	modport sink   (input valid, input hit, input mem_read, input mem_write,
		input way_used, input config_error, output ready);
endinterface

### design/sacc_line_ram.sv
// ---------------------------------------------------------------------------
// sacc_line_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sacc_line_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/sacc_addr_split.sv
// ---------------------------------------------------------------------------
// sacc_addr_split: address decode
// Splits a byte address into memory row, lane offset and tag under the
// current geometry, and flags unusable geometry.
// ---------------------------------------------------------------------------
module sacc_addr_split (
	input  sacc_pkg::cfg_t                       cfg,
	input  logic [sacc_pkg::ADDRESS_BITS-1:0]    address,
	output logic [sacc_pkg::ROW_BITS-1:0]        row,
	output logic [sacc_pkg::LANE_BITS-1:0]       off,
	output logic [sacc_pkg::TAG_BITS-1:0]        tag,
	output logic                                 bad
);
	import sacc_pkg::*;

	logic [TAG_BITS-1:0]       blk;
	logic [LINES_CFG_BITS-1:0] set_bits;
	logic [LINE_BITS-1:0]      set_idx;
	logic [LINE_BITS-1:0]      base;

	always_comb begin
		bad = ({1'b0, cfg.ways_log2} > cfg.lines_log2)
			|| (cfg.lines_log2 > LINES_CFG_BITS'(MAX_LINES_LOG2))
			|| (cfg.ways_log2 > WAYS_CFG_BITS'(MAX_WAYS_LOG2));
		blk      = address[ADDRESS_BITS-1:OFFSET_BITS];
		set_bits = cfg.lines_log2 - LINES_CFG_BITS'(cfg.ways_log2);
		set_idx  = blk[LINE_BITS-1:0] & ~({LINE_BITS{1'b1}} << set_bits);
		tag      = blk >> set_bits;
		base     = set_idx << cfg.ways_log2;
		row      = base[LINE_BITS-1:LANE_BITS];
		off      = base[LANE_BITS-1:0];
	end

endmodule

### design/sacc_set_update.sv
// ---------------------------------------------------------------------------
// sacc_set_update: set lookup and replacement
// Compares the ways of one set, picks hit, free or victim way, and builds
// the updated memory row with new tag, flags and ages.
// ---------------------------------------------------------------------------
module sacc_set_update (
	input  sacc_pkg::cfg_t                  cfg,
	input  sacc_pkg::row_t                  cur,
	input  logic [sacc_pkg::TAG_BITS-1:0]   tag,
	input  logic [sacc_pkg::LANE_BITS-1:0]  off,
	input  logic                            is_write,
	output sacc_pkg::row_t                  nxt,
	output sacc_pkg::res_t                  res
);
	import sacc_pkg::*;

	localparam int KEY_BITS = RANK_BITS + 1;

	logic [LANES-1:0]     in_set;
	logic [LANES-1:0]     hit_vec;
	logic [LANES-1:0]     free_vec;
	logic                 any_hit;
	logic                 any_free;
	logic [LANE_BITS-1:0] hit_lane;
	logic [LANE_BITS-1:0] free_lane;
	logic [LANE_BITS-1:0] vict_lane;
	logic [LANE_BITS-1:0] sel;
	logic [KEY_BITS-1:0]  key [2*LANES];
	logic [LANE_BITS-1:0] kidx [2*LANES];
	logic                 replace;
	logic                 fresh;
	logic [KEY_BITS-1:0]  old_use;
	logic [KEY_BITS-1:0]  old_fill;
	logic [LANE_BITS-1:0] way_mask;

	// way membership and match vectors
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			in_set[i]   = ((LANE_BITS'(i) ^ off) >> cfg.ways_log2) == '0;
			hit_vec[i]  = in_set[i] && cur[i].valid && (cur[i].tag == tag);
			free_vec[i] = in_set[i] && !cur[i].valid;
		end
		any_hit   = |hit_vec;
		any_free  = |free_vec;
		hit_lane  = '0;
		free_lane = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_lane = LANE_BITS'(i);
			end
			if (free_vec[i]) begin
				free_lane = LANE_BITS'(i);
			end
		end
	end

	// oldest-way tree, lower lane wins ties
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			key[LANES + i]  = {in_set[i],
				(cfg.repl == REPL_FIFO) ? cur[i].fill_rank : cur[i].use_rank};
			kidx[LANES + i] = LANE_BITS'(i);
		end
		key[0]  = '0;
		kidx[0] = '0;
		for (int n = LANES - 1; n >= 1; n--) begin
			if (key[2*n] >= key[2*n+1]) begin
				key[n]  = key[2*n];
				kidx[n] = kidx[2*n];
			end else begin
				key[n]  = key[2*n+1];
				kidx[n] = kidx[2*n+1];
			end
		end
		vict_lane = kidx[1];
	end

	// row update
	always_comb begin
		replace  = !any_hit && !any_free;
		fresh    = !any_hit && any_free;
		sel      = any_hit ? hit_lane : (any_free ? free_lane : vict_lane);
		old_use  = fresh ? KEY_BITS'(1 << RANK_BITS) : {1'b0, cur[sel].use_rank};
		old_fill = fresh ? KEY_BITS'(1 << RANK_BITS) : {1'b0, cur[sel].fill_rank};
		nxt      = cur;
		for (int i = 0; i < LANES; i++) begin
			if (in_set[i] && cur[i].valid && (LANE_BITS'(i) != sel)) begin
				if (({1'b0, cur[i].use_rank} < old_use) && (cur[i].use_rank != RANK_MAX)) begin
					nxt[i].use_rank = cur[i].use_rank + 1'b1;
				end
				if (!any_hit && ({1'b0, cur[i].fill_rank} < old_fill)
						&& (cur[i].fill_rank != RANK_MAX)) begin
					nxt[i].fill_rank = cur[i].fill_rank + 1'b1;
				end
			end
		end
		nxt[sel].use_rank = '0;
		if (any_hit) begin
			nxt[sel].dirty = cur[sel].dirty | is_write;
		end else begin
			nxt[sel].fill_rank = '0;
			nxt[sel].tag       = tag;
			nxt[sel].valid     = 1'b1;
			nxt[sel].dirty     = is_write;
		end

		way_mask         = ~({LANE_BITS{1'b1}} << cfg.ways_log2);
		res.hit          = any_hit;
		res.mem_read     = !any_hit;
		res.mem_write    = (is_write && (cfg.wpol != WPOL_BACK))
			|| (replace && (cfg.wpol == WPOL_BACK) && cur[sel].dirty);
		res.way          = sel & way_mask;
		res.config_error = 1'b0;
	end

endmodule

### design/set_assoc_cache_tag_controller.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_controller: set-associative cache tag controller
// Tag lookup with LRU or FIFO replacement, write-through or write-back.
// ---------------------------------------------------------------------------
// Each request beat carries a read or write and a 48-bit byte address; each
// produces exactly one response beat (hit, memory read, memory write, way,
// configuration error). Line state (tag, valid, dirty, recency and arrival
// ages) lives in one synchronous RAM of 64 rows, each row holding 16 lines,
// so any set of up to 16 ways sits in a single row. A request is one RAM
// read-modify-write: the accept edge issues the row read; once the response
// register is free, the update state writes the updated row back and loads
// the response register. Since the next read is issued only after the write,
// no forwarding is needed. The next request is accepted the cycle after the
// response is registered, even if that response has not yet been taken; a
// finished lookup waits only for the response register to drain. After reset
// the block clears all 64 rows of the RAM, one row per cycle, and takes
// no request until done; configuration writes are taken at any time but must
// only change while no request is in flight. A geometry change keeps all
// line state and reinterprets it. Unusable geometry (ways_log2 above
// lines_log2, or either above its maximum) returns config_error with all
// other fields zero and leaves state untouched.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	sacc_req_if.sink                          req,
	sacc_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [sacc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sacc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import sacc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t               state_q;
	logic [ROW_BITS-1:0]  clr_row_q;
	cfg_t                 cfg_q;

	// lookup stage registers
	logic [ROW_BITS-1:0]  row_s1;
	logic [LANE_BITS-1:0] off_s1;
	logic [TAG_BITS-1:0]  tag_s1;
	logic                 wr_s1;
	logic                 bad_s1;

	// response register
	logic                 rsp_valid_q;
	res_t                 rsp_q;

	logic [ROW_BITS-1:0]  dec_row;
	logic [LANE_BITS-1:0] dec_off;
	logic [TAG_BITS-1:0]  dec_tag;
	logic                 dec_bad;
	logic                 accept;
	logic                 rsp_free;
	logic                 finish;
	row_t                 rd_row;
	row_t                 upd_row;
	res_t                 upd_res;
	logic                 ram_we;
	logic [ROW_BITS-1:0]  ram_waddr;
	row_t                 ram_wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repl       <= 1'b0;
			cfg_q.wpol       <= 1'b0;
			cfg_q.lines_log2 <= LINES_CFG_BITS'(MAX_LINES_LOG2);
			cfg_q.ways_log2  <= WAYS_CFG_BITS'(2);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_REPLACEMENT: cfg_q.repl       <= cfg_wdata[0];
				REG_WRITE_POL:   cfg_q.wpol       <= cfg_wdata[0];
				REG_LINES_LOG2:  cfg_q.lines_log2 <= cfg_wdata[LINES_CFG_BITS-1:0];
				REG_WAYS_LOG2:   cfg_q.ways_log2  <= cfg_wdata[WAYS_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	sacc_addr_split u_split (
		.cfg     (cfg_q),
		.address (req.address),
		.row     (dec_row),
		.off     (dec_off),
		.tag     (dec_tag),
		.bad     (dec_bad)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == ST_UPDATE) && rsp_free;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_row_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == ROW_BITS'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// request fields held for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= dec_row;
			off_s1 <= dec_off;
			tag_s1 <= dec_tag;
			wr_s1  <= (req.req_type == REQ_WRITE);
			bad_s1 <= dec_bad;
		end
	end

	sacc_set_update u_update (
		.cfg      (cfg_q),
		.cur      (rd_row),
		.tag      (tag_s1),
		.off      (off_s1),
		.is_write (wr_s1),
		.nxt      (upd_row),
		.res      (upd_res)
	);

	// RAM write: clearing sweep or row write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_row_q;
			ram_wdata = '0;
		end else begin
			ram_we    = finish && !bad_s1;
			ram_waddr = row_s1;
			ram_wdata = upd_row;
		end
	end

	sacc_line_ram #(
		.DEPTH (ROWS),
		.WIDTH ($bits(row_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (dec_row),
		.rdata (rd_row)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (bad_s1) begin
				rsp_q <= '{hit: 1'b0, mem_read: 1'b0, mem_write: 1'b0, way: '0,
					config_error: 1'b1};
			end else begin
				rsp_q <= upd_res;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = rsp_q.hit;
	assign rsp.mem_read     = rsp_q.mem_read;
	assign rsp.mem_write    = rsp_q.mem_write;
	assign rsp.way_used     = rsp_q.way;
	assign rsp.config_error = rsp_q.config_error;

endmodule
